### hdl/commit_log_predecessor_table_unit_assert.svh
// assertion macros shared by the commit log table modules
`ifndef COMMIT_LOG_PREDECESSOR_TABLE_UNIT_ASSERT_SVH
`define COMMIT_LOG_PREDECESSOR_TABLE_UNIT_ASSERT_SVH

// property checked on every clock edge outside reset
`define CLPT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define CLPT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### hdl/clpt_pkg.sv
// types and codes shared by the commit log table modules
package clpt_pkg;

    typedef enum logic [1:0] {
        OP_APPEND  = 2'd0,
        OP_QUERY   = 2'd1,
        OP_MARK    = 2'd2,
        OP_COMPACT = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_FETCH,
        ST_CMP_RD,
        ST_CMP_WR
    } state_t;

    typedef struct packed {
        logic init;
        logic step;
    } search_ctrl_t;

    localparam int TIME_W  = 64;
    localparam int ENTRY_W = 9;

endpackage

### hdl/clpt_log_mem.sv
// commit and start time storage, one write and one registered read per cycle
module clpt_log_mem #(
    parameter int DEPTH = 256,
    parameter int IDX_W = 8
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [IDX_W-1:0]           waddr,
    input  logic [clpt_pkg::TIME_W-1:0] wcommit,
    input  logic [clpt_pkg::TIME_W-1:0] wstart,
    input  logic [IDX_W-1:0]           raddr,
    output logic [clpt_pkg::TIME_W-1:0] rcommit,
    output logic [clpt_pkg::TIME_W-1:0] rstart
);
    import clpt_pkg::*;

    logic [TIME_W-1:0] commit_mem [DEPTH];
    logic [TIME_W-1:0] start_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            commit_mem[waddr] <= wcommit;
            start_mem[waddr]  <= wstart;
        end
        rcommit <= commit_mem[raddr];
        rstart  <= start_mem[raddr];
    end

endmodule

### hdl/clpt_search_unit.sv
// lower-bound search step unit: window registers, midpoint add and 64-bit compare
module clpt_search_unit #(
    parameter int CNT_W = 9,
    parameter int IDX_W = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  clpt_pkg::search_ctrl_t      ctrl,
    input  logic [CNT_W-1:0]            count,
    input  logic [clpt_pkg::TIME_W-1:0] probe,
    input  logic [clpt_pkg::TIME_W-1:0] key,
    output logic [IDX_W-1:0]            mid_idx,
    output logic [IDX_W-1:0]            pred_idx,
    output logic                        len_zero,
    output logic                        first_zero
);
    import clpt_pkg::*;

    logic [CNT_W-1:0] first_reg, first_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] half;
    logic [CNT_W-1:0] mid;
    logic [CNT_W-1:0] pred;
    logic             less;

    assign half       = len_reg >> 1;
    assign mid        = first_reg + half;
    assign pred       = first_reg - CNT_W'(1);
    assign less       = key < probe;
    assign mid_idx    = mid[IDX_W-1:0];
    assign pred_idx   = pred[IDX_W-1:0];
    assign len_zero   = (len_reg == '0);
    assign first_zero = (first_reg == '0);

    always_comb
    begin
        first_next = first_reg;
        len_next   = len_reg;
        if (ctrl.init)
        begin
            first_next = '0;
            len_next   = count;
        end
        else if (ctrl.step)
        begin
            if (less)
            begin
                first_next = mid + CNT_W'(1);
                len_next   = len_reg - half - CNT_W'(1);
            end
            else
            begin
                len_next = half;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= '0;
            len_reg   <= '0;
        end
        else
        begin
            first_reg <= first_next;
            len_reg   <= len_next;
        end
    end

`include "commit_log_predecessor_table_unit_assert.svh"
    `CLPT_ASSERT(a_step_nonempty, ctrl.step |-> !len_zero, "search step on empty window")
    `CLPT_ASSERT(a_len_shrinks, ctrl.step && !ctrl.init |=> len_reg < $past(len_reg), "search window did not shrink")
    `CLPT_NEVER(a_ctrl_both, ctrl.init && ctrl.step, "search init and step together")

endmodule

### hdl/commit_log_predecessor_table_unit.sv
// top level of the commit log predecessor table: sequencer, keep marks, result registers
//
// usage
// - command channel: an item (operation, commit_time, probe_time) is taken at a rising
//   edge with start high and busy low; busy stays high while the item is worked on
// - result channel: done is high for exactly one cycle with found, result_time and
//   status; entry_count always shows the current number of valid entries and is
//   already updated in the done cycle; the receiver cannot stall, so nothing waits
// - append and compact on a table that is not full: done in the cycle after the accept
// - query and mark: a lower-bound binary search, each halving step a memory read,
//   then a compare in the shared search unit; then a read of the predecessor and
//   a fetch state that takes its start time when an entry is found
// - compact on a full table: each entry is read, then a kept one is written to its
//   packed slot, in a read state and a write state since the log memory read is registered;
//   keep marks are cleared one per entry along the walk
// - a new item may be started in the same cycle that done is high
// - reset clears the entry count and all keep marks; the log memory holds no reset
//   value and is only ever read below the entry count
module commit_log_predecessor_table_unit #(
    parameter int LOG_CAPACITY = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    operation,
    input  logic [clpt_pkg::TIME_W-1:0]   commit_time,
    input  logic [clpt_pkg::TIME_W-1:0]   probe_time,
    output logic                          done,
    output logic                          found,
    output logic [clpt_pkg::TIME_W-1:0]   result_time,
    output logic                          status,
    output logic [clpt_pkg::ENTRY_W-1:0]  entry_count
);
    import clpt_pkg::*;

    localparam int CNT_W = $clog2(LOG_CAPACITY + 1);
    localparam int IDX_W = $clog2(LOG_CAPACITY);
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(LOG_CAPACITY);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(LOG_CAPACITY - 1);

    // sequencer and table state
    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [LOG_CAPACITY-1:0] keep_reg, keep_next;
    logic                    done_reg, done_next;

    // item and result registers
    op_t               op_reg, op_next;
    logic [TIME_W-1:0] probe_reg, probe_next;
    logic              found_reg, found_next;
    logic [TIME_W-1:0] rtime_reg, rtime_next;
    logic              status_reg, status_next;

    // compaction read and write pointers
    logic [CNT_W-1:0] r_reg, r_next;
    logic [CNT_W-1:0] w_reg, w_next;
    logic             keep_rd_reg, keep_rd_next;
    logic             kept;

    // memory port
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [TIME_W-1:0] mem_wcommit;
    logic [TIME_W-1:0] mem_wstart;
    logic [IDX_W-1:0]  mem_raddr;
    logic [TIME_W-1:0] mem_rcommit;
    logic [TIME_W-1:0] mem_rstart;

    // search unit
    search_ctrl_t     sctrl;
    logic [IDX_W-1:0] sch_mid;
    logic [IDX_W-1:0] sch_pred;
    logic             sch_len_zero;
    logic             sch_first_zero;

    clpt_log_mem #(
        .DEPTH (LOG_CAPACITY),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wcommit (mem_wcommit),
        .wstart  (mem_wstart),
        .raddr   (mem_raddr),
        .rcommit (mem_rcommit),
        .rstart  (mem_rstart)
    );

    clpt_search_unit #(
        .CNT_W (CNT_W),
        .IDX_W (IDX_W)
    ) u_search (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (sctrl),
        .count      (count_reg),
        .probe      (probe_reg),
        .key        (mem_rcommit),
        .mid_idx    (sch_mid),
        .pred_idx   (sch_pred),
        .len_zero   (sch_len_zero),
        .first_zero (sch_first_zero)
    );

    // keep mark of the entry under the read pointer, registered alongside the memory read
    assign keep_rd_next = keep_reg[r_reg[IDX_W-1:0]];

    // last entry always survives a compaction, marked ones too
    assign kept = keep_rd_reg || (r_reg == LAST_CNT);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        keep_next   = keep_reg;
        done_next   = 1'b0;
        op_next     = op_reg;
        probe_next  = probe_reg;
        found_next  = found_reg;
        rtime_next  = rtime_reg;
        status_next = status_reg;
        r_next      = r_reg;
        w_next      = w_reg;
        mem_we      = 1'b0;
        mem_waddr   = count_reg[IDX_W-1:0];
        mem_wcommit = commit_time;
        mem_wstart  = probe_time;
        mem_raddr   = sch_mid;
        sctrl       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next     = op_t'(operation);
                    probe_next  = probe_time;
                    found_next  = 1'b0;
                    rtime_next  = '0;
                    status_next = 1'b0;
                    case (op_t'(operation))
                        OP_APPEND:
                        begin
                            if (count_reg >= CAP_CNT)
                            begin
                                status_next = 1'b1;
                            end
                            else
                            begin
                                mem_we = 1'b1;
                                keep_next[count_reg[IDX_W-1:0]] = 1'b0;
                                count_next = count_reg + CNT_W'(1);
                            end
                            done_next = 1'b1;
                        end
                        OP_QUERY, OP_MARK:
                        begin
                            // a zero probe finds nothing, so a mark with it is a no-op
                            sctrl.init = 1'b1;
                            state_next = ST_SRCH_RD;
                        end
                        OP_COMPACT:
                        begin
                            if (count_reg == CAP_CNT)
                            begin
                                r_next     = '0;
                                w_next     = '0;
                                state_next = ST_CMP_RD;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SRCH_RD:
            begin
                if (sch_len_zero)
                begin
                    if (sch_first_zero)
                    begin
                        // no entry below the probe
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        mem_raddr  = sch_pred;
                        state_next = ST_FETCH;
                    end
                end
                else
                begin
                    mem_raddr  = sch_mid;
                    state_next = ST_SRCH_CMP;
                end
            end
            ST_SRCH_CMP:
            begin
                sctrl.step = 1'b1;
                state_next = ST_SRCH_RD;
            end
            ST_FETCH:
            begin
                found_next = 1'b1;
                rtime_next = mem_rstart;
                if (op_reg == OP_MARK)
                begin
                    keep_next[sch_pred] = 1'b1;
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_CMP_RD:
            begin
                mem_raddr  = r_reg[IDX_W-1:0];
                state_next = ST_CMP_WR;
            end
            ST_CMP_WR:
            begin
                mem_waddr   = w_reg[IDX_W-1:0];
                mem_wcommit = mem_rcommit;
                mem_wstart  = mem_rstart;
                if (kept)
                begin
                    mem_we = 1'b1;
                    w_next = w_reg + CNT_W'(1);
                end
                // the walk visits every entry, so this leaves all marks clear
                keep_next[r_reg[IDX_W-1:0]] = 1'b0;
                r_next = r_reg + CNT_W'(1);
                if (r_reg == LAST_CNT)
                begin
                    count_next = w_reg + {{(CNT_W-1){1'b0}}, kept};
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_CMP_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            keep_reg  <= '0;
            done_reg  <= 1'b0;
            op_reg    <= OP_APPEND;
            r_reg     <= '0;
            w_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            keep_reg  <= keep_next;
            done_reg  <= done_next;
            op_reg    <= op_next;
            r_reg     <= r_next;
            w_reg     <= w_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        probe_reg   <= probe_next;
        found_reg   <= found_next;
        rtime_reg   <= rtime_next;
        status_reg  <= status_next;
        keep_rd_reg <= keep_rd_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign found       = found_reg;
    assign result_time = rtime_reg;
    assign status      = status_reg;
    assign entry_count = ENTRY_W'(count_reg);

`include "commit_log_predecessor_table_unit_assert.svh"
    `CLPT_NEVER(a_count_max, count_reg > CAP_CNT, "entry count above capacity")
    `CLPT_ASSERT(a_drop_full, done_reg && status_reg |-> count_reg == CAP_CNT, "append dropped on a table that is not full")
    `CLPT_ASSERT(a_found_op, done_reg && found_reg |-> (op_reg == OP_QUERY || op_reg == OP_MARK), "found set for append or compact")
    `CLPT_ASSERT(a_pack_order, state_reg == ST_CMP_WR |-> w_reg <= r_reg, "compaction write pointer passed read pointer")
    `CLPT_ASSERT(a_compact_clear, $past(state_reg == ST_CMP_WR) && state_reg == ST_IDLE |-> keep_reg == '0, "keep marks left after compaction")

endmodule
